>>> hdl/pis_pkg.sv
// Shared constants, tables and helpers for the pendulum integrator.
`default_nettype none
package pis_pkg;

   localparam int ANG_W   = 34;   // working width of the CORDIC angle and vector
   localparam int SUM_W   = 40;   // RK4 increment sums and divider dividend
   localparam int MUL_W   = 33;   // signed operand width of the shared multiplier
   localparam int PROD_W  = 2 * MUL_W;

   localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd843314857;
   localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd421657428;
   localparam logic signed [ANG_W-1:0] CORDIC_X0   = 34'sd652032874;

   localparam logic signed [31:0] ANGLE_RESET = 32'sd210828715;
   localparam logic [31:0] GOL_RESET  = 32'd164584489;
   localparam logic [31:0] GAIN_RESET = 32'd16777216;

   localparam logic [7:0] REG_MODE      = 8'd0;
   localparam logic [7:0] REG_FREE_FALL = 8'd1;
   localparam logic [7:0] REG_GOL       = 8'd2;
   localparam logic [7:0] REG_GAIN      = 8'd3;

   localparam logic REQ_TORQUE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd210828714;
         5'd1:  v = 34'sd124459457;
         5'd2:  v = 34'sd65760959;
         5'd3:  v = 34'sd33381290;
         5'd4:  v = 34'sd16755422;
         5'd5:  v = 34'sd8385879;
         5'd6:  v = 34'sd4193963;
         5'd7:  v = 34'sd2097109;
         5'd8:  v = 34'sd1048571;
         5'd9:  v = 34'sd524287;
         5'd10: v = 34'sd262144;
         5'd11: v = 34'sd131072;
         5'd12: v = 34'sd65536;
         5'd13: v = 34'sd32768;
         5'd14: v = 34'sd16384;
         5'd15: v = 34'sd8192;
         5'd16: v = 34'sd4096;
         5'd17: v = 34'sd2048;
         5'd18: v = 34'sd1024;
         5'd19: v = 34'sd512;
         5'd20: v = 34'sd256;
         5'd21: v = 34'sd128;
         5'd22: v = 34'sd64;
         5'd23: v = 34'sd32;
         5'd24: v = 34'sd16;
         5'd25: v = 34'sd8;
         5'd26: v = 34'sd4;
         5'd27: v = 34'sd2;
         5'd28: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/pis_mul.sv
// Shared signed 33x33 multiplier with registered product.
`default_nettype none
module pis_mul (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [pis_pkg::MUL_W-1:0] op_a,
   input  wire logic signed [pis_pkg::MUL_W-1:0] op_b,
   output logic signed [pis_pkg::PROD_W-1:0] product,
   output logic done
);
   import pis_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
      if (start) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign product = prod_ff;
   assign done    = done_ff;
endmodule
`default_nettype wire

>>> hdl/pis_cordic.sv
// Iterative rotation-mode CORDIC sine, one micro-rotation per cycle.
`default_nettype none
module pis_cordic #(
   parameter int ITERATIONS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [31:0] theta,
   output logic signed [pis_pkg::MUL_W-1:0] sine,
   output logic done
);
   import pis_pkg::*;

   localparam int CW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

   logic signed [ANG_W-1:0] x_ff, y_ff, z_ff;
   logic [CW-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic signed [ANG_W-1:0] t0, t1, t2, dx, dy, at;
   logic [4:0] idx;

   always_comb begin
      t0 = {{(ANG_W-32){theta[31]}}, theta};
      if (t0 > ANG_PI) begin
         t1 = t0 - ANG_TWO_PI;
      end else if (t0 < -ANG_PI) begin
         t1 = t0 + ANG_TWO_PI;
      end else begin
         t1 = t0;
      end
      // mirror about +-pi/2 so the rotation converges
      if (t1 > ANG_HALF_PI) begin
         t2 = ANG_PI - t1;
      end else if (t1 < -ANG_HALF_PI) begin
         t2 = -ANG_PI - t1;
      end else begin
         t2 = t1;
      end
      idx = 5'(cnt_ff);
      dx  = y_ff >>> idx;
      dy  = x_ff >>> idx;
      at  = atan_lookup(idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CW'(ITERATIONS - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            x_ff    <= CORDIC_X0;
            y_ff    <= '0;
            z_ff    <= t2;
         end else if (busy_ff) begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
            if (cnt_ff == CW'(ITERATIONS - 1)) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   assign sine = y_ff[MUL_W-1:0];
   assign done = done_ff;
endmodule
`default_nettype wire

>>> hdl/pis_div6.sv
// Signed divide by six, truncating toward zero, one byte of the dividend per cycle.
`default_nettype none
module pis_div6 (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [pis_pkg::SUM_W-1:0] dividend,
   output logic signed [pis_pkg::SUM_W-1:0] quotient,
   output logic done
);
   import pis_pkg::*;

   localparam int CHUNKS = SUM_W / 8;
   localparam int CNT_W  = $clog2(CHUNKS);
   // ceil(2^14 / 6): exact floor(v / 6) for every v below 6 * 256
   localparam logic [23:0] RECIP6 = 24'd2731;
   localparam logic [10:0] SIX    = 11'd6;

   logic [SUM_W-1:0] mag_ff, quo_ff;
   logic [2:0] rem_ff;
   logic neg_ff, busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [10:0] part, back, diff;
   logic [23:0] scaled;
   logic [7:0] digit;

   always_comb begin
      // partial remainder below 6, then the next byte of the magnitude
      part   = {rem_ff, mag_ff[SUM_W-1 -: 8]};
      scaled = {13'd0, part} * RECIP6;
      digit  = scaled[21:14];
      back   = {3'd0, digit} * SIX;
      diff   = part - back;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CNT_W'(CHUNKS - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= '0;
            neg_ff  <= dividend[SUM_W-1];
            mag_ff  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         end else if (busy_ff) begin
            mag_ff <= mag_ff << 8;
            rem_ff <= diff[2:0];
            quo_ff <= {quo_ff[SUM_W-9:0], digit};
            if (cnt_ff == CNT_W'(CHUNKS - 1)) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

>>> hdl/pendulum_integrator_step.sv
// Pendulum integrator top level: sequencer, state and handshake ports.
// Torque item: goes straight to the completion state and its result is registered once
// the output register is free. Tick: the CORDIC loop dominates the work; the multiplier,
// and with RK4 the divide by six, add the rest.
// One item in work at a time; the next is taken the cycle after the result is registered.
// Synchronous reset restores angle pi/4, zero rate and torque, and register defaults.
`default_nettype none
module pendulum_integrator_step #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic req_type,
   input  wire logic signed [31:0] req_torque_in,
   input  wire logic [23:0] req_time_step,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [31:0] rsp_angle_out,
   output logic signed [31:0] rsp_rate_out,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [7:0] csr_index,
   input  wire logic [31:0] csr_data
);
   import pis_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DRV_WAIT, S_SIN_WAIT, S_GRAV_WAIT, S_DR_WAIT, S_DA_WAIT,
      S_DIV_T, S_DIV_W, S_DONE
   } state_type;

   state_type state_ff;
   logic mode_ff, free_fall_ff;
   logic [31:0] gol_ff, gain_ff;
   logic signed [31:0] angle_ff, rate_ff, held_torque_ff, th_w_ff, om_w_ff;
   logic [23:0] dt_ff;
   logic [1:0] stage_ff;
   logic signed [49:0] drive_ff;
   logic signed [SUM_W-1:0] kw_ff, sum_t_ff, sum_w_ff;
   logic mul_start_ff, cor_start_ff, div_start_ff;
   logic signed [MUL_W-1:0] mul_a_ff, mul_b_ff;
   logic signed [31:0] cor_theta_ff;
   logic signed [SUM_W-1:0] div_in_ff;
   logic rsp_valid_ff;
   logic signed [31:0] rsp_angle_ff, rsp_rate_ff;

   logic signed [PROD_W-1:0] product;
   logic mul_done, cor_done, div_done;
   logic signed [MUL_W-1:0] sine;
   logic signed [SUM_W-1:0] quotient;

   logic signed [35:0] grav;
   logic signed [31:0] accel;
   logic signed [SUM_W-1:0] kt, kt_w, kw_w, sum_t_in, sum_w_in, kt_h, kw_h;
   logic signed [31:0] th_w_in, om_w_in, eul_angle, eul_rate;
   logic out_free, load_rsp;
   logic mul_start_in, cor_start_in, div_start_in;

   pis_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start_ff),
      .op_a(mul_a_ff), .op_b(mul_b_ff), .product(product), .done(mul_done)
   );

   pis_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start_ff),
      .theta(cor_theta_ff), .sine(sine), .done(cor_done)
   );

   pis_div6 u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend(div_in_ff), .quotient(quotient), .done(div_done)
   );

   always_comb begin
      grav  = product[65:30];
      accel = sat32({{14{drive_ff[49]}}, drive_ff} - {{28{grav[35]}}, grav});
      kt    = product[59:20];
      // RK4 weights: outer stages once, inner stages twice
      kt_w  = (stage_ff == 2'd0 || stage_ff == 2'd3) ? kt : (kt <<< 1);
      kw_w  = (stage_ff == 2'd0 || stage_ff == 2'd3) ? kw_ff : (kw_ff <<< 1);
      sum_t_in = sum_t_ff + kt_w;
      sum_w_in = sum_w_ff + kw_w;
      kt_h  = (stage_ff == 2'd2) ? kt : (kt >>> 1);
      kw_h  = (stage_ff == 2'd2) ? kw_ff : (kw_ff >>> 1);
      th_w_in = sat32({{32{angle_ff[31]}}, angle_ff} + {{24{kt_h[SUM_W-1]}}, kt_h});
      om_w_in = sat32({{32{rate_ff[31]}}, rate_ff} + {{24{kw_h[SUM_W-1]}}, kw_h});
      eul_angle = sat32({{32{angle_ff[31]}}, angle_ff} + {{24{kt[SUM_W-1]}}, kt});
      eul_rate  = sat32({{32{rate_ff[31]}}, rate_ff} + {{24{kw_ff[SUM_W-1]}}, kw_ff});
      out_free  = !rsp_valid_ff || !rsp_stall;
      load_rsp  = (state_ff == S_DONE) && out_free;
      mul_start_in = (state_ff == S_IDLE && req_valid && req_type == REQ_TICK) ||
                     (state_ff == S_SIN_WAIT && cor_done) ||
                     ((state_ff == S_GRAV_WAIT || state_ff == S_DR_WAIT) && mul_done);
      cor_start_in = (state_ff == S_DRV_WAIT && mul_done) ||
                     (state_ff == S_DA_WAIT && mul_done && mode_ff && stage_ff != 2'd3);
      div_start_in = (state_ff == S_DA_WAIT && mul_done && mode_ff && stage_ff == 2'd3) ||
                     (state_ff == S_DIV_T && div_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mode_ff        <= 1'b0;
         free_fall_ff   <= 1'b1;
         gol_ff         <= GOL_RESET;
         gain_ff        <= GAIN_RESET;
         angle_ff       <= ANGLE_RESET;
         rate_ff        <= '0;
         held_torque_ff <= '0;
         mul_start_ff   <= 1'b0;
         cor_start_ff   <= 1'b0;
         div_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mul_start_ff <= mul_start_in;
         cor_start_ff <= cor_start_in;
         div_start_ff <= div_start_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               REG_MODE:      mode_ff      <= csr_data[0];
               REG_FREE_FALL: free_fall_ff <= csr_data[0];
               REG_GOL:       gol_ff       <= csr_data;
               REG_GAIN:      gain_ff      <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  dt_ff <= req_time_step;
                  if (req_type == REQ_TORQUE) begin
                     held_torque_ff <= free_fall_ff ? '0 : req_torque_in;
                     state_ff       <= S_DONE;
                  end else begin
                     if (free_fall_ff) begin
                        held_torque_ff <= '0;
                     end
                     th_w_ff      <= angle_ff;
                     om_w_ff      <= rate_ff;
                     stage_ff     <= 2'd0;
                     sum_t_ff     <= '0;
                     sum_w_ff     <= '0;
                     mul_a_ff     <= free_fall_ff ? '0 :
                                     {held_torque_ff[31], held_torque_ff};
                     mul_b_ff     <= {1'b0, gain_ff};
                     state_ff     <= S_DRV_WAIT;
                  end
               end
            end
            S_DRV_WAIT: begin
               if (mul_done) begin
                  drive_ff     <= product[65:16];
                  cor_theta_ff <= th_w_ff;
                  state_ff     <= S_SIN_WAIT;
               end
            end
            S_SIN_WAIT: begin
               if (cor_done) begin
                  mul_a_ff     <= {1'b0, gol_ff};
                  mul_b_ff     <= sine;
                  state_ff     <= S_GRAV_WAIT;
               end
            end
            S_GRAV_WAIT: begin
               if (mul_done) begin
                  mul_a_ff     <= {9'd0, dt_ff};
                  mul_b_ff     <= {accel[31], accel};
                  state_ff     <= S_DR_WAIT;
               end
            end
            S_DR_WAIT: begin
               if (mul_done) begin
                  kw_ff        <= product[63:24];
                  mul_a_ff     <= {9'd0, dt_ff};
                  mul_b_ff     <= {om_w_ff[31], om_w_ff};
                  state_ff     <= S_DA_WAIT;
               end
            end
            S_DA_WAIT: begin
               if (mul_done) begin
                  if (!mode_ff) begin
                     angle_ff <= eul_angle;
                     rate_ff  <= eul_rate;
                     state_ff <= S_DONE;
                  end else if (stage_ff == 2'd3) begin
                     sum_w_ff     <= sum_w_in;
                     div_in_ff    <= sum_t_in;
                     state_ff     <= S_DIV_T;
                  end else begin
                     sum_t_ff     <= sum_t_in;
                     sum_w_ff     <= sum_w_in;
                     th_w_ff      <= th_w_in;
                     om_w_ff      <= om_w_in;
                     stage_ff     <= stage_ff + 2'd1;
                     cor_theta_ff <= th_w_in;
                     state_ff     <= S_SIN_WAIT;
                  end
               end
            end
            S_DIV_T: begin
               if (div_done) begin
                  angle_ff <= sat32({{32{angle_ff[31]}}, angle_ff} +
                                    {{24{quotient[SUM_W-1]}}, quotient});
                  div_in_ff    <= sum_w_ff;
                  state_ff     <= S_DIV_W;
               end
            end
            S_DIV_W: begin
               if (div_done) begin
                  rate_ff  <= sat32({{32{rate_ff[31]}}, rate_ff} +
                                    {{24{quotient[SUM_W-1]}}, quotient});
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // hold the result until the output register frees up
               if (out_free) begin
                  rsp_angle_ff <= angle_ff;
                  rsp_rate_ff  <= rate_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_out = rsp_angle_ff;
   assign rsp_rate_out  = rsp_rate_ff;

   a_mul_done_follows_start: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> $past(mul_start_ff))
      else $error("multiplier done without start");

   a_free_fall_torque: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRV_WAIT && free_fall_ff) |-> (held_torque_ff == 32'sd0))
      else $error("held torque not cleared in free fall");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

   a_single_unit_busy: assert property (@(posedge clock) disable iff (reset)
      cor_start_ff |-> !mul_start_ff && !div_start_ff)
      else $error("two shared units started together");

endmodule
`default_nettype wire

>>> verif/pis_checker.sv
// Pendulum integrator checker: state predictor and result comparison.
`timescale 1ns / 100ps
module pis_checker #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_stall,
   input  wire logic req_type,
   input  wire logic signed [31:0] req_torque_in,
   input  wire logic [23:0] req_time_step,
   input  wire logic rsp_valid,
   input  wire logic rsp_stall,
   input  wire logic signed [31:0] rsp_angle_out,
   input  wire logic signed [31:0] rsp_rate_out,
   input  wire logic csr_valid,
   input  wire logic csr_ready,
   input  wire logic [7:0] csr_index,
   input  wire logic [31:0] csr_data,
   output int fail_count,
   output int pending
);
   import pis_pkg::*;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
   } pend_state_type;

   pend_state_type expected_states[$];

   logic        rk4_mode;
   logic        free_fall;
   logic [31:0] gravity_over_len;
   logic [31:0] gain;
   logic signed [31:0] cur_angle, cur_rate, cur_torque;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint sine_q30(input longint theta);
      longint t, x, y, dx, dy, step;
      t = theta;
      x = 64'sd652032874;
      y = 0;
      if (t > 64'sd843314857) t = t - 64'sd1686629713;
      else if (t < -64'sd843314857) t = t + 64'sd1686629713;
      // mirror into [-pi/2, pi/2]
      if (t > 64'sd421657428) t = 64'sd843314857 - t;
      else if (t < -64'sd421657428) t = -64'sd843314857 - t;
      for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         step = longint'(atan_lookup(5'(i)));
         if (t >= 0) begin
            x = x - dx; y = y + dy; t = t - step;
         end else begin
            x = x + dx; y = y - dy; t = t + step;
         end
      end
      return y;
   endfunction

   function automatic longint accel(input longint theta);
      longint grav, drive;
      grav  = (longint'({32'd0, gravity_over_len}) * sine_q30(theta)) >>> 30;
      drive = (longint'(cur_torque) * longint'({32'd0, gain})) >>> 16;
      return clamp32(drive - grav);
   endfunction

   function automatic longint angle_step(input longint dt, input longint rate);
      return (dt * rate) >>> 20;
   endfunction

   function automatic longint rate_step(input longint dt, input longint acc);
      return (dt * acc) >>> 24;
   endfunction

   task automatic advance(input logic [23:0] time_step);
      longint dt, th, om, k1t, k2t, k3t, k4t, k1w, k2w, k3w, k4w;
      dt = longint'({40'd0, time_step});
      th = cur_angle;
      om = cur_rate;
      if (!rk4_mode) begin
         k1t = angle_step(dt, om);
         k1w = rate_step(dt, accel(th));
         cur_angle = 32'(clamp32(th + k1t));
         cur_rate  = 32'(clamp32(om + k1w));
      end else begin
         k1t = angle_step(dt, om);
         k1w = rate_step(dt, accel(th));
         k2t = angle_step(dt, clamp32(om + (k1w >>> 1)));
         k2w = rate_step(dt, accel(clamp32(th + (k1t >>> 1))));
         k3t = angle_step(dt, clamp32(om + (k2w >>> 1)));
         k3w = rate_step(dt, accel(clamp32(th + (k2t >>> 1))));
         k4t = angle_step(dt, clamp32(om + k3w));
         k4w = rate_step(dt, accel(clamp32(th + k3t)));
         cur_angle = 32'(clamp32(th + (k1t + 2 * k2t + 2 * k3t + k4t) / 6));
         cur_rate  = 32'(clamp32(om + (k1w + 2 * k2w + 2 * k3w + k4w) / 6));
      end
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t: mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      pend_state_type want;
      if (reset) begin
         rk4_mode = 1'b0;
         free_fall = 1'b1;
         gravity_over_len = GOL_RESET;
         gain = GAIN_RESET;
         cur_angle = ANGLE_RESET;
         cur_rate = '0;
         cur_torque = '0;
         expected_states.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               report("unexpected item", rsp_angle_out, 0);
            end else begin
               want = expected_states.pop_front();
               if (rsp_angle_out !== want.angle) report("angle", rsp_angle_out, want.angle);
               if (rsp_rate_out !== want.rate) report("rate", rsp_rate_out, want.rate);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:      rk4_mode = csr_data[0];
               REG_FREE_FALL: free_fall = csr_data[0];
               REG_GOL:       gravity_over_len = csr_data;
               REG_GAIN:      gain = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_type == REQ_TORQUE) begin
               cur_torque = free_fall ? 32'sd0 : req_torque_in;
            end else begin
               if (free_fall) cur_torque = '0;
               advance(req_time_step);
            end
            want.angle = cur_angle;
            want.rate  = cur_rate;
            expected_states = {expected_states, want};
         end
      end
      pending <= expected_states.size();
   end

endmodule

>>> verif/testbench.sv
// Testbench top: stimulus, idling phases and verdict for the pendulum integrator.
`timescale 1ns / 100ps
module testbench;
   import pis_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = REQ_TORQUE;
   logic signed [31:0] req_torque_in = '0;
   logic [23:0] req_time_step = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_angle_out, rsp_rate_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   int fail_count, pending;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycles = 0;

   localparam int CYCLE_LIMIT = 3000000;

   pendulum_integrator_step u_top (.*);

   pis_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Called at a falling edge; leaves valid high so back-to-back items need no drop.
   task automatic send_item(input logic kind, input logic [31:0] torque,
                            input logic [23:0] dt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_type <= kind;
      req_torque_in <= torque;
      req_time_step <= dt;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
      drain();
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [23:0] random_dt;
      case ($urandom_range(9))
         0: return 24'($urandom);
         1: return 24'(0);
         default: return 24'($urandom_range(100000));
      endcase
   endfunction

   task automatic random_item;
      if ($urandom_range(3) == 0) send_item(REQ_TORQUE, $urandom, 24'($urandom));
      else send_item(REQ_TICK, $urandom, random_dt());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: defaults (Euler, free fall), extremes of the fields
      send_item(REQ_TORQUE, 32'h7FFF_FFFF, 24'h0);
      send_item(REQ_TICK, 32'h0, 24'd16777);
      send_item(REQ_TICK, 32'h0, 24'h0);
      send_item(REQ_TICK, 32'hFFFF_FFFF, 24'hFF_FFFF);
      write_reg(REG_FREE_FALL, 32'h0);
      send_item(REQ_TORQUE, 32'h8000_0000, 24'hFF_FFFF);
      send_item(REQ_TICK, 32'h0, 24'd1000);
      send_item(REQ_TORQUE, 32'h7FFF_FFFF, 24'h0);
      send_item(REQ_TICK, 32'h0, 24'hFF_FFFF);
      send_item(REQ_TICK, 32'h0, 24'hFF_FFFF);
      write_reg(REG_MODE, 32'hFFFF_FFFF);
      send_item(REQ_TICK, 32'h0, 24'hFF_FFFF);
      send_item(REQ_TORQUE, 32'h0001_0000, 24'h0);
      send_item(REQ_TICK, 32'h0, 24'h0);
      write_reg(REG_GOL, 32'hFFFF_FFFF);
      write_reg(REG_GAIN, 32'hFFFF_FFFF);
      send_item(REQ_TICK, 32'h0, 24'd65536);
      send_item(REQ_TORQUE, 32'h8000_0000, 24'h0);
      send_item(REQ_TICK, 32'h0, 24'd65536);
      write_reg(8'hFF, 32'hFFFF_FFFF);
      write_reg(8'd4, 32'h0);
      write_reg(REG_GOL, 32'h0);
      write_reg(REG_GAIN, 32'h0);
      send_item(REQ_TICK, 32'h0, 24'd4096);
      write_reg(REG_FREE_FALL, 32'h1);
      send_item(REQ_TORQUE, 32'h1234_5678, 24'h0);
      send_item(REQ_TICK, 32'h0, 24'd4096);

      // random: walk through settings and idling phases
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         write_reg(REG_MODE, $urandom_range(1));
         write_reg(REG_FREE_FALL, 32'((phase % 3) == 0));
         case (phase)
            0: write_reg(REG_GOL, GOL_RESET);
            5: write_reg(REG_GOL, 32'hFFFF_FFFF);
            default: write_reg(REG_GOL, $urandom_range(32'h2000_0000));
         endcase
         case (phase)
            1: write_reg(REG_GAIN, 32'h0);
            6: write_reg(REG_GAIN, 32'hFFFF_FFFF);
            default: write_reg(REG_GAIN, $urandom);
         endcase
         for (int n = 0; n < 54; n++) random_item();
         if (phase == 3) begin
            // hold off until every result is back
            drain();
         end
      end

      drain();
      stall_pct = 0;
      repeat (250) @(negedge clock);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/pis_pkg.sv
hdl/pis_mul.sv
hdl/pis_cordic.sv
hdl/pis_div6.sv
hdl/pendulum_integrator_step.sv
verif/pis_checker.sv
verif/testbench.sv
